// File: rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared widths, register map and reset values of the skin conductance
// converter.
// ----------------------------------------------------------------------------
package scc_pkg;

  // Configuration port geometry.
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // Register word indices (taken from paddr[3:2]).
  localparam logic [1:0] RegOpenThr   = 2'd0;
  localparam logic [1:0] RegSpikeLim  = 2'd1;
  localparam logic [1:0] RegGain      = 2'd2;

  // Field widths fixed by the register and stream definitions.
  localparam int unsigned SampleW  = 16;
  localparam int unsigned CondW    = 16;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned LimitW   = 27;
  localparam int unsigned GainW    = 11;

  // Register reset values.
  localparam logic [ThrW-1:0]   OpenThrRst  = 16'hF3C0;
  localparam logic [LimitW-1:0] SpikeLimRst = 27'd21000;
  localparam logic [GainW-1:0]  GainRst     = 11'd2000;

  // Saturation ceiling of the conductance output.
  localparam logic [CondW-1:0]  CondMax     = 16'hFFFF;

endpackage

// File: rtl/skin_conductance_converter.sv
// ----------------------------------------------------------------------------
// skin_conductance_converter
// Turns one ADC word of a skin-resistance divider into a scaled conductance
// gain*(2^ADC_BITS - adc)/adc, with open-circuit detection, spike rejection
// against the last accepted value and saturation to 16 bits.
//
//   Channel   Direction  tdata (low bit up)       tuser (low bit up)
//   s_axis    in         adc_sample[15:0]         -
//   m_axis    out        conductance[15:0]        open_circuit, spike_held
//   apb       cfg        0x0 open_threshold, 0x4 spike_limit, 0x8 gain
//
// A word below the threshold passes through the multiply state, the
// restoring divider and the compare state, which loads the result into the
// output register; the sequencer then returns to idle and can take the next
// word. An open-circuit word goes from idle straight to the compare state.
// The divider is a single shared subtract/shift unit; it sets the rate.
// s_axis_tready is high only while the sequencer is idle. A finished result
// waits in the compare state while the output register is still occupied,
// which adds the output stall cycles to the word.
// Reset clears the stored conductance and loads register defaults.
// ----------------------------------------------------------------------------
module skin_conductance_converter
  import scc_pkg::*;
#(
  parameter int unsigned ADC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Sample stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SampleW-1:0]  s_axis_tdata,   // [15:0] adc_sample
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [CondW-1:0]    m_axis_tdata,   // [15:0] conductance
  output logic [1:0]          m_axis_tuser,   // [0] open_circuit, [1] spike_held
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned NumW   = GainW + ADC_BITS;
  localparam int unsigned DiffW  = (NumW > LimitW) ? NumW : LimitW;
  localparam int unsigned CntW   = $clog2(NumW + 1);
  localparam logic [CntW-1:0] LastStep = CntW'(NumW - 1);

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StDiv,
    StCmp
  } state_e;

  // Configuration registers.
  logic [ThrW-1:0]   open_thr_q;
  logic [LimitW-1:0] spike_lim_q;
  logic [GainW-1:0]  gain_q;

  // Sequencer and datapath registers.
  state_e              state_q;
  logic                open_q;
  logic [ADC_BITS-1:0] div_q;
  logic [ADC_BITS:0]   rem_q;
  logic [NumW-1:0]     quo_q;
  logic [CntW-1:0]     cnt_q;
  logic [CondW-1:0]    last_q;
  logic                out_vld_q;
  logic [CondW-1:0]    out_data_q;
  logic [1:0]          out_user_q;

  // Combinational datapath signals.
  logic [ADC_BITS-1:0] adc_w;
  logic [ADC_BITS-1:0] adc_nz;
  logic [ADC_BITS-1:0] sub_w;
  logic [NumW-1:0]     prod_w;
  logic [ADC_BITS:0]   shifted_w;
  logic [ADC_BITS+1:0] trial_w;
  logic                neg_w;
  logic [DiffW-1:0]    raw_x;
  logic [DiffW-1:0]    last_x;
  logic [DiffW-1:0]    diff_w;
  logic                spike_w;
  logic [CondW-1:0]    sat_w;
  logic                out_free;
  logic                out_load;
  logic                in_acc;
  logic                cfg_wr;

  // ---------------------------------------------------------------------
  // Configuration port: writes on the access cycle, reads return values.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_thr_q  <= OpenThrRst;
      spike_lim_q <= SpikeLimRst;
      gain_q      <= GainRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegOpenThr:  open_thr_q  <= pwdata[ThrW-1:0];
        RegSpikeLim: spike_lim_q <= pwdata[LimitW-1:0];
        RegGain:     gain_q      <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegOpenThr:  prdata = ApbDataW'(open_thr_q);
      RegSpikeLim: prdata = ApbDataW'(spike_lim_q);
      RegGain:     prdata = ApbDataW'(gain_q);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input conditioning: mask to the converter width, zero reads as one.
  // ---------------------------------------------------------------------
  assign adc_w  = s_axis_tdata[ADC_BITS-1:0];
  assign adc_nz = (adc_w == '0) ? ADC_BITS'(1) : adc_w;

  // Full scale minus the sample; exact in ADC_BITS bits because div_q >= 1.
  assign sub_w  = ADC_BITS'(0) - div_q;
  assign prod_w = NumW'(gain_q) * NumW'(sub_w);

  // One restoring divider step per cycle.
  assign shifted_w = {rem_q[ADC_BITS-1:0], quo_q[NumW-1]};
  assign trial_w   = {1'b0, shifted_w} - {2'b00, div_q};
  assign neg_w     = trial_w[ADC_BITS+1];

  // Spike check on the unsaturated quotient and saturation to 16 bits.
  assign raw_x   = DiffW'(quo_q);
  assign last_x  = DiffW'(last_q);
  assign diff_w  = (raw_x >= last_x) ? (raw_x - last_x) : (last_x - raw_x);
  assign spike_w = diff_w > DiffW'(spike_lim_q);
  assign sat_w   = (|quo_q[NumW-1:CondW]) ? CondMax : quo_q[CondW-1:0];

  assign out_free = !out_vld_q || m_axis_tready;
  assign out_load = (state_q == StCmp) && out_free;
  assign in_acc   = s_axis_tvalid && (state_q == StIdle);

  // ---------------------------------------------------------------------
  // Sequencer with its datapath and the output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      open_q     <= 1'b0;
      div_q      <= '0;
      rem_q      <= '0;
      quo_q      <= '0;
      cnt_q      <= '0;
      last_q     <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      out_user_q <= '0;
    end else begin
      // The output register takes a finished result, else drops a taken word.
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            div_q <= adc_nz;
            if (CondW'(adc_w) >= open_thr_q) begin
              open_q  <= 1'b1;
              state_q <= StCmp;
            end else begin
              open_q  <= 1'b0;
              state_q <= StMul;
            end
          end
        end
        StMul: begin
          quo_q   <= prod_w;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          rem_q <= neg_w ? shifted_w : trial_w[ADC_BITS:0];
          quo_q <= {quo_q[NumW-2:0], ~neg_w};
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == LastStep) begin
            state_q <= StCmp;
          end
        end
        StCmp: begin
          if (out_free) begin
            priority if (open_q) begin
              out_data_q <= '0;
              out_user_q <= 2'b01;
            end else if (spike_w) begin
              out_data_q <= last_q;
              out_user_q <= 2'b10;
            end else begin
              out_data_q <= sat_w;
              out_user_q <= 2'b00;
              last_q     <= sat_w;
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
